// ----- hdl/kcc_pkg.sv -----
// ----------------------------------------------------------------------------
// kcc_pkg
// Shared types and constants of the key click classifier: the lane phase
// codes, the per-lane event bundle and the configuration register map.
// ----------------------------------------------------------------------------
package kcc_pkg;

  // Width of the key level input and of each result field.
  localparam int unsigned KeyBits = 4;

  // Counter and configuration register width.
  localparam int unsigned CntW = 8;
  localparam logic [CntW-1:0] CntMax = 8'hFF;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CfgLongLimit    = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgDoubleWindow = 4'd1;

  // Reset values of the configuration registers.
  localparam logic [CntW-1:0] LongLimitRst    = 8'd70;
  localparam logic [CntW-1:0] DoubleWindowRst = 8'd35;

  // Debounce phase of one key lane. The unused code is treated as idle.
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_CONFIRM = 2'd1,
    PH_HELD    = 2'd2
  } phase_e;

  // Events that one lane reports for one scan tick.
  typedef struct packed {
    logic short_press;
    logic double_press;
    logic long_hold;
  } kcc_evt_t;

endpackage

// ----- hdl/kcc_lane.sv -----
// ----------------------------------------------------------------------------
// kcc_lane
// One key lane: debounce machine (idle, confirm, held), held-time counter and
// double-click window. Updates its state once per accepted scan tick and
// reports that tick's events combinationally.
// ----------------------------------------------------------------------------
module kcc_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          tick_i,
  input  logic                          pressed_i,
  input  logic [kcc_pkg::CntW-1:0]      long_limit_i,
  input  logic [kcc_pkg::CntW-1:0]      double_window_i,
  output kcc_pkg::kcc_evt_t             evt_o
);
  import kcc_pkg::*;

  phase_e          phase_q, phase_d;
  logic [CntW-1:0] held_q, held_d;
  logic            wopen_q, wopen_d;
  logic [CntW-1:0] wcnt_q, wcnt_d;

  logic            wopen_mid;
  logic [CntW-1:0] wcnt_mid;
  logic            is_long;

  assign is_long = (held_q > long_limit_i);

  // Next-state logic for the debounce machine and the press counters.
  always_comb begin
    phase_d          = phase_q;
    held_d           = held_q;
    wopen_mid        = wopen_q;
    wcnt_mid         = wcnt_q;
    evt_o            = '0;
    case (phase_q)
      PH_CONFIRM: begin
        phase_d = pressed_i ? PH_HELD : PH_IDLE;
      end
      PH_HELD: begin
        if (!pressed_i) begin
          if (!is_long) begin
            if (!wopen_q) begin
              wopen_mid = 1'b1;
              wcnt_mid  = '0;
            end else begin
              evt_o.double_press = 1'b1;
              wopen_mid          = 1'b0;
            end
          end
          phase_d = PH_IDLE;
        end else begin
          evt_o.long_hold = is_long;
          if (held_q != CntMax) begin
            held_d = held_q + 1'b1;
          end
        end
      end
      default: begin
        if (pressed_i) begin
          phase_d = PH_CONFIRM;
          held_d  = '0;
        end else begin
          phase_d = PH_IDLE;
        end
      end
    endcase

    // The double-click window runs after the phase update.
    wopen_d = wopen_mid;
    wcnt_d  = wcnt_mid;
    if (wopen_mid) begin
      if (wcnt_mid != CntMax) begin
        wcnt_d = wcnt_mid + 1'b1;
      end
      if (wcnt_d >= double_window_i) begin
        evt_o.short_press = 1'b1;
        wopen_d           = 1'b0;
      end
    end
  end

  // Lane state advances only on an accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      held_q  <= '0;
      wopen_q <= 1'b0;
      wcnt_q  <= '0;
    end else if (tick_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      wopen_q <= wopen_d;
      wcnt_q  <= wcnt_d;
    end
  end

endmodule

// ----- hdl/kcc_merge.sv -----
// ----------------------------------------------------------------------------
// kcc_merge
// Gathers the events of all lanes into the three result fields and holds
// them in an output register with a skid stage, so that a new item can be
// taken while a finished result still waits downstream.
// ----------------------------------------------------------------------------
module kcc_merge #(
  parameter int unsigned NUM_KEYS = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  kcc_pkg::kcc_evt_t            evt_i [NUM_KEYS],
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [kcc_pkg::KeyBits-1:0]  short_press_o,
  output logic [kcc_pkg::KeyBits-1:0]  double_press_o,
  output logic [kcc_pkg::KeyBits-1:0]  long_hold_o
);
  import kcc_pkg::*;

  typedef struct packed {
    logic [KeyBits-1:0] sp;
    logic [KeyBits-1:0] dp;
    logic [KeyBits-1:0] lh;
  } res_t;

  res_t new_res;
  res_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;
  logic accept, take;

  // Pack the visible lanes; lanes past the field width are dropped.
  for (genvar k = 0; k < KeyBits; k++) begin : g_pack
    if (k < NUM_KEYS) begin : g_lane
      assign new_res.sp[k] = evt_i[k].short_press;
      assign new_res.dp[k] = evt_i[k].double_press;
      assign new_res.lh[k] = evt_i[k].long_hold;
    end else begin : g_none
      assign new_res.sp[k] = 1'b0;
      assign new_res.dp[k] = 1'b0;
      assign new_res.lh[k] = 1'b0;
    end
  end

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;
  assign take       = out_valid_q && !out_stall_i;

  // Valid flags of the output register and the skid stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q || take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (!out_valid_q || take) begin
        out_q <= new_res;
      end else begin
        skid_q <= new_res;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign short_press_o  = out_q.sp;
  assign double_press_o = out_q.dp;
  assign long_hold_o    = out_q.lh;

endmodule

// ----- hdl/key_click_classifier.sv -----
// ----------------------------------------------------------------------------
// key_click_classifier
// Short, double and long press detector for a bank of active-low keys.
// ----------------------------------------------------------------------------
// The block takes one scan tick per item and can accept an item in every
// clock cycle while in_stall_o is low; each item yields exactly one result,
// registered in the output register. Every key has its own lane that
// updates in the cycle the item is accepted, and a merge stage with a skid
// register keeps taking one more item while the output is stalled. Results
// are one-tick event bits: short_press when the double-click window expires,
// double_press on the second quick release, and long_hold on every tick a key
// stays down past long_limit. Keys above the four input bits read as released.
// The user must write configuration only while idle; it is not enforced.
// ----------------------------------------------------------------------------
module key_click_classifier #(
  parameter int unsigned NUM_KEYS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port.
  input  logic                          cfg_we_i,
  input  logic [kcc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [kcc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Scan tick input.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [kcc_pkg::KeyBits-1:0]   key_levels_i,
  // Result output.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [kcc_pkg::KeyBits-1:0]   short_press_o,
  output logic [kcc_pkg::KeyBits-1:0]   double_press_o,
  output logic [kcc_pkg::KeyBits-1:0]   long_hold_o
);
  import kcc_pkg::*;

  logic [CntW-1:0] long_limit_q;
  logic [CntW-1:0] double_window_q;
  logic            tick;
  kcc_evt_t        evt [NUM_KEYS];

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_limit_q    <= LongLimitRst;
      double_window_q <= DoubleWindowRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLongLimit:    long_limit_q    <= cfg_wdata_i;
        CfgDoubleWindow: double_window_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign tick = in_valid_i && !in_stall_o;

  // One lane per key.
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic pressed;
    if (k < KeyBits) begin : g_in
      assign pressed = !key_levels_i[k];
    end else begin : g_none
      assign pressed = 1'b0;
    end

    kcc_lane u_lane (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .tick_i          (tick),
      .pressed_i       (pressed),
      .long_limit_i    (long_limit_q),
      .double_window_i (double_window_q),
      .evt_o           (evt[k])
    );
  end

  kcc_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .evt_i          (evt),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .short_press_o  (short_press_o),
    .double_press_o (double_press_o),
    .long_hold_o    (long_hold_o)
  );

endmodule
